FILE: sv/pqcf_pkg.sv
// ----------------------------------------------------------------------------
// pqcf_pkg
// Shared types, codes and constants of the three-level strict-priority queue.
// ----------------------------------------------------------------------------
package pqcf_pkg;

  // Default sizing of the store.
  localparam int CAPACITY_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed field widths of the channels.
  localparam int HANDLE_W  = 16;
  localparam int PRI_W     = 2;
  localparam int OCC_W     = 7;
  localparam int EVT_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int NUM_LEVELS = 3;

  // Packed channel widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_DROP_EN = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_THRESH  = 2'd2;

  localparam logic             DROP_EN_RST = 1'b1;
  localparam logic [OCC_W-1:0] LIMIT_RST   = 7'd64;
  localparam logic [OCC_W-1:0] THRESH_RST  = 7'd32;

  // Operation kinds.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Priority levels; the unused code is served as high.
  localparam logic [PRI_W-1:0] PRI_LOW  = 2'd0;
  localparam logic [PRI_W-1:0] PRI_MED  = 2'd1;
  localparam logic [PRI_W-1:0] PRI_HIGH = 2'd2;
  localparam logic [PRI_W-1:0] PRI_RSVD = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic             drop_en;
    logic [OCC_W-1:0] limit;
    logic [OCC_W-1:0] thresh;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted item
    logic exec;    // decide, update pointers, access the store
    logic finish;  // congestion update and result register load
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    priority_lvl;
    logic [OCC_W-1:0]    occupancy;
    logic                congested;
    logic [EVT_W-1:0]    events;
  } result_t;

endpackage

FILE: sv/pqcf_regs.sv
// ----------------------------------------------------------------------------
// pqcf_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pqcf_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqcf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pqcf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pqcf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output pqcf_pkg::cfg_t                   cfg
);
  import pqcf_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_en <= DROP_EN_RST;
      cfg_r.limit   <= LIMIT_RST;
      cfg_r.thresh  <= THRESH_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DROP_EN: cfg_r.drop_en <= pwdata[0];
        REG_LIMIT:   cfg_r.limit   <= pwdata[OCC_W-1:0];
        REG_THRESH:  cfg_r.thresh  <= pwdata[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DROP_EN: prdata = CFG_DATA_W'(cfg_r.drop_en);
      REG_LIMIT:   prdata = CFG_DATA_W'(cfg_r.limit);
      REG_THRESH:  prdata = CFG_DATA_W'(cfg_r.thresh);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: sv/pqcf_ctrl.sv
// ----------------------------------------------------------------------------
// pqcf_ctrl
// Sequencer: accept an item, run the queue operation, then hand the result
// to the output register once it is free.
// ----------------------------------------------------------------------------
module pqcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pqcf_pkg::dp_stat_t stat,
  output pqcf_pkg::cmd_t     cmd
);
  import pqcf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // The read data of a dequeue is ready here; wait for the result slot.
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/pqcf_dp.sv
// ----------------------------------------------------------------------------
// pqcf_dp
// Datapath: per-level ring buffers with head/tail/count, occupancy,
// hysteresis congestion flag with event counter, and the result register.
// ----------------------------------------------------------------------------
module pqcf_dp #(
  parameter int CAPACITY    = pqcf_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = pqcf_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pqcf_pkg::cmd_t                 cmd,
  input  pqcf_pkg::cfg_t                 cfg,
  input  logic                           in_action,
  input  logic [pqcf_pkg::PRI_W-1:0]     in_priority,
  input  logic [pqcf_pkg::HANDLE_W-1:0]  in_handle,
  output pqcf_pkg::dp_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output pqcf_pkg::result_t              result
);
  import pqcf_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int WIDE_W = (HANDLE_BITS > HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  // Item under work.
  logic                   act_r;
  logic [PRI_W-1:0]       lvl_r;
  logic [HANDLE_BITS-1:0] hnd_r;

  // Queue state.
  logic [IDX_W-1:0] head_r [NUM_LEVELS];
  logic [IDX_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];
  logic [CNT_W-1:0] occ_r;
  logic             flag_r;
  logic [EVT_W-1:0] evt_r;

  // Outcome of the operation, held until the result is built.
  logic [STATUS_W-1:0]    sts_r;
  logic                   hit_r;
  logic [PRI_W-1:0]       olvl_r;
  logic [HANDLE_BITS-1:0] rd_r;

  result_t res_r;
  logic    out_valid_r;

  logic [HANDLE_BITS-1:0] mem_lo [CAPACITY];
  logic [HANDLE_BITS-1:0] mem_md [CAPACITY];
  logic [HANDLE_BITS-1:0] mem_hi [CAPACITY];

  logic [WIDE_W-1:0]   in_wide;
  logic [WIDE_W-1:0]   rd_wide;
  logic [CMP_W-1:0]    occ_c;
  logic [CMP_W-1:0]    thr_c;
  logic                at_limit;
  logic                full;
  logic                deq_any;
  logic [PRI_W-1:0]    deq_lvl;
  logic                do_enq;
  logic                do_deq;
  logic [STATUS_W-1:0] sts_c;
  logic                set_c;
  logic                clr_c;
  logic                flag_nxt;
  logic [EVT_W-1:0]    evt_nxt;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    next_slot = (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign in_wide = WIDE_W'(in_handle);
  assign rd_wide = WIDE_W'(rd_r);

  // Decision for the item under work.
  assign occ_c    = CMP_W'(occ_r);
  assign at_limit = cfg.drop_en && (occ_c >= CMP_W'(cfg.limit)) && (lvl_r != PRI_HIGH);
  assign full     = (occ_r == CNT_W'(CAPACITY));

  always_comb begin
    deq_any = 1'b1;
    if (cnt_r[2] != '0) begin
      deq_lvl = PRI_HIGH;
    end else if (cnt_r[1] != '0) begin
      deq_lvl = PRI_MED;
    end else begin
      deq_lvl = PRI_LOW;
      deq_any = (cnt_r[0] != '0);
    end
  end

  always_comb begin
    if (act_r == ACT_DEQ) begin
      sts_c = deq_any ? ST_DONE : ST_EMPTY;
    end else if (at_limit) begin
      sts_c = ST_LIMIT;
    end else if (full) begin
      sts_c = ST_FULL;
    end else begin
      sts_c = ST_DONE;
    end
  end

  assign do_enq = cmd.exec && (act_r == ACT_ENQ) && !at_limit && !full;
  assign do_deq = cmd.exec && (act_r == ACT_DEQ) && deq_any;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      lvl_r <= (in_priority == PRI_RSVD) ? PRI_HIGH : in_priority;
      hnd_r <= in_wide[HANDLE_BITS-1:0];
    end
    if (cmd.exec) begin
      sts_r  <= sts_c;
      hit_r  <= (act_r == ACT_DEQ) && deq_any;
      olvl_r <= deq_lvl;
    end
  end

  // One write and one read port per level store.
  always_ff @(posedge clk) begin
    if (do_enq) begin
      case (lvl_r)
        PRI_LOW: mem_lo[tail_r[0]] <= hnd_r;
        PRI_MED: mem_md[tail_r[1]] <= hnd_r;
        default: mem_hi[tail_r[2]] <= hnd_r;
      endcase
    end
    if (do_deq) begin
      case (deq_lvl)
        PRI_LOW: rd_r <= mem_lo[head_r[0]];
        PRI_MED: rd_r <= mem_md[head_r[1]];
        default: rd_r <= mem_hi[head_r[2]];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      occ_r <= '0;
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (do_enq && lvl_r == PRI_W'(i)) begin
          tail_r[i] <= next_slot(tail_r[i]);
          cnt_r[i]  <= cnt_r[i] + 1'b1;
        end
        if (do_deq && deq_lvl == PRI_W'(i)) begin
          head_r[i] <= next_slot(head_r[i]);
          cnt_r[i]  <= cnt_r[i] - 1'b1;
        end
      end
      if (do_enq) begin
        occ_r <= occ_r + 1'b1;
      end else if (do_deq) begin
        occ_r <= occ_r - 1'b1;
      end
    end
  end

  // Hysteresis: set at the threshold, clear below half of it.
  assign thr_c = CMP_W'(cfg.thresh);
  assign set_c = (occ_c >= thr_c);
  assign clr_c = (occ_c < (thr_c >> 1));

  always_comb begin
    flag_nxt = flag_r;
    evt_nxt  = evt_r;
    if (set_c) begin
      flag_nxt = 1'b1;
      if (!flag_r && evt_r != '1) begin
        evt_nxt = evt_r + 1'b1;
      end
    end else if (clr_c) begin
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b0;
      evt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        flag_r      <= flag_nxt;
        evt_r       <= evt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r.status       <= sts_r;
      res_r.hit          <= hit_r;
      res_r.handle       <= hit_r ? rd_wide[HANDLE_W-1:0] : '0;
      res_r.priority_lvl <= hit_r ? olvl_r : PRI_LOW;
      res_r.occupancy    <= OCC_W'(occ_r);
      res_r.congested    <= flag_nxt;
      res_r.events       <= evt_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign result        = res_r;

  a_occ_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+2)'(occ_r) == (CNT_W+2)'(cnt_r[0]) + (CNT_W+2)'(cnt_r[1]) + (CNT_W+2)'(cnt_r[2]))
    else $error("occupancy differs from the sum of the level counts");

  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy beyond the store capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && act_r == ACT_DEQ && !deq_any |-> occ_r == '0)
    else $error("dequeue found no item while occupancy is nonzero");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flag_r) && $past(evt_r) != '1 |-> evt_r == $past(evt_r) + 1'b1)
    else $error("congestion rise not counted");

endmodule

FILE: sv/priority_queue_with_congestion_flag_core.sv
// ----------------------------------------------------------------------------
// priority_queue_with_congestion_flag_core
// Three-level strict-priority queue of message handles with a hysteresis
// congestion flag and a saturating count of its rising edges.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                       content
//  in_      slave      tvalid/tready                   one enqueue or dequeue
//  out_     master     tvalid/tready                   one result per item
//  cfg_     APB slave  psel/penable/pwrite, pready=1   three config registers
//
//  An item passes through accept, the queue operation with the store access,
//  then the result load from the registered store read, once the output is free.
//  A new item is accepted again in the cycle after the result load.
//  A result held in the output register does not block the next item until
//  that item is ready to load its own result.
//  Reset is synchronous and active low; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module priority_queue_with_congestion_flag_core #(
  parameter int CAPACITY    = pqcf_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = pqcf_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] priority_req, [17:2] message_handle
  input  logic [pqcf_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  logic [pqcf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] out_handle, [17:16] out_priority, [24:18] occupancy,
  // [25] congested, [41:26] congestion_events
  output logic [pqcf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status, [2] hit
  output logic [pqcf_pkg::OUT_USER_W-1:0]  out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pqcf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pqcf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pqcf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import pqcf_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t stat;
  result_t  res;

  pqcf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pqcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pqcf_dp #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_action   (in_tuser[0]),
    .in_priority (in_tdata[1:0]),
    .in_handle   (in_tdata[17:2]),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .result      (res)
  );

  assign out_tdata = {6'b0, res.events, res.congested, res.occupancy,
                      res.priority_lvl, res.handle};
  assign out_tuser = {res.hit, res.status};

endmodule
